// ----- rtl/base64_decoder_strict_core_macros.svh -----
// Assertion macros shared by the base64 decoder RTL.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef BASE64_DECODER_STRICT_CORE_MACROS_SVH
`define BASE64_DECODER_STRICT_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define B64D_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("b64d assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define B64D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("b64d assertion failed");

`endif

// ----- rtl/b64d_pkg.sv -----
// Types, constants and the alphabet lookup for the strict base64 decoder.
// Depends on nothing; used by b64d_decode and base64_decoder_strict_core.
`timescale 1ns / 1ps

package b64d_pkg;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  // Position of the next character inside its quartet.
  localparam logic [1:0] QPOS_FIRST  = 2'd0;
  localparam logic [1:0] QPOS_SECOND = 2'd1;
  localparam logic [1:0] QPOS_THIRD  = 2'd2;
  localparam logic [1:0] QPOS_FOURTH = 2'd3;

  localparam logic [7:0] CH_PAD     = 8'h3D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;

  localparam logic [5:0] SX_LOWER_BASE = 6'd26;
  localparam logic [5:0] SX_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SX_PLUS       = 6'd62;
  localparam logic [5:0] SX_SLASH      = 6'd63;

  localparam int unsigned MaxResults = 4;

  typedef struct packed {
    logic [1:0]  pos;
    logic [17:0] acc;
    logic        third_pad;
    logic        err;
  } state_t;

  typedef struct packed {
    logic [7:0] byte_value;
    kind_e      kind;
  } result_t;

  // Results caused by one input character, slot 0 first.
  typedef struct packed {
    logic [2:0]               num_res;
    result_t [MaxResults-1:0] res;
  } group_t;

  // Returns {valid, sextet}; valid is low for characters outside the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [6:0] r;
    r = '0;
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      r = {1'b1, 6'(ch - CH_UPPER_A)};
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      r = {1'b1, 6'(ch - CH_LOWER_A) + SX_LOWER_BASE};
    end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
      r = {1'b1, 6'(ch - CH_DIGIT_0) + SX_DIGIT_BASE};
    end else if (ch == CH_PLUS) begin
      r = {1'b1, SX_PLUS};
    end else if (ch == CH_SLASH) begin
      r = {1'b1, SX_SLASH};
    end
    return r;
  endfunction

endpackage

// ----- rtl/base64_decoder_strict_core.sv -----
// Strict base64 decoder: one character in per cycle, decoded bytes and an end
// status out one per cycle while the receiver is ready, through a small queue
// of result groups. Each character is decoded in a single pass of b64d_decode,
// and the results it causes (up to three bytes and a status) are written to
// the queue in the same cycle. A new character is taken every cycle while the
// queue has room; the output side drains one result per transfer, so the three
// bytes of a quartet leave one after another there, and the queue of FIFO_DEPTH
// groups absorbs that burst. A message whose status is ended-with-error must be
// discarded in full by the consumer, including bytes sent before the error was
// found. Depends on b64d_pkg and b64d_decode.
`timescale 1ns / 1ps

module base64_decoder_strict_core
  import b64d_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_code
  input  logic       s_axis_tlast_i,   // end_of_message
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] byte_value
  output logic [1:0] m_axis_tuser_o,   // [1:0] kind
  output logic       m_axis_tlast_o    // last_of_run
);

`include "base64_decoder_strict_core_macros.svh"

  localparam int unsigned AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  state_t          state_q, state_d;
  group_t          grp;
  group_t          fifo_q [FIFO_DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [1:0]      idx_q, idx_d;
  logic            s_fire;
  logic            m_fire;
  logic            push;
  logic            pop;
  logic            out_last;
  group_t          head;
  result_t         cur;

  b64d_decode u_decode (
    .state_i          (state_q),
    .char_code_i      (s_axis_tdata_i),
    .end_of_message_i (s_axis_tlast_i),
    .state_o          (state_d),
    .group_o          (grp)
  );

  assign s_axis_tready_o = (cnt_q != CW'(FIFO_DEPTH));
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign push            = s_fire && (grp.num_res != 3'd0);

  assign head     = fifo_q[rd_ptr_q];
  assign cur      = head.res[idx_q];
  assign out_last = ((3'({1'b0, idx_q}) + 3'd1) == head.num_res);

  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = cur.byte_value;
  assign m_axis_tuser_o  = cur.kind;
  assign m_axis_tlast_o  = out_last;
  assign m_fire          = m_axis_tvalid_o && m_axis_tready_i;
  assign pop             = m_fire && out_last;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (m_fire) begin
      idx_d = out_last ? 2'd0 : idx_q + 2'd1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
    end else begin
      if (s_fire) begin
        state_q <= state_d;
      end
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
    end
  end

  // Group storage needs no reset; entries are read only once written.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= grp;
    end
  end

  `B64D_ASSERT(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(FIFO_DEPTH))
  `B64D_ASSERT(a_head_nonempty, clk_i, rst_ni, m_axis_tvalid_o, head.num_res != 3'd0)
  `B64D_ASSERT(a_status_last, clk_i, rst_ni,
               m_axis_tvalid_o && m_axis_tuser_o != KIND_DATA,
               m_axis_tlast_o && m_axis_tdata_o == 8'h00)
  `B64D_ASSERT_NEXT(a_msg_end_clears, clk_i, rst_ni, s_fire && s_axis_tlast_i,
                    state_q.pos == QPOS_FIRST && !state_q.err)

endmodule

// ----- rtl/b64d_decode.sv -----
// Next-state and result logic for one character of the strict base64 decoder.
// Purely combinational; depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_decode
  import b64d_pkg::*;
(
  input  state_t     state_i,
  input  logic [7:0] char_code_i,
  input  logic       end_of_message_i,
  output state_t     state_o,
  output group_t     group_o
);

  logic [6:0]  sx;
  logic [5:0]  v;
  logic        bad;
  logic        is_pad;
  logic        err;
  logic        pad2;
  logic        pad3;
  logic [5:0]  d;
  logic [23:0] value;
  logic [2:0]  n;

  always_comb begin
    sx      = sextet_of(char_code_i);
    v       = sx[5:0];
    bad     = !sx[6];
    is_pad  = (char_code_i == CH_PAD);
    err     = state_i.err;
    pad2    = state_i.third_pad;
    pad3    = is_pad;
    d       = '0;
    value   = '0;
    n       = '0;
    state_o = state_i;
    group_o = '0;

    case (state_i.pos)
      QPOS_FIRST: begin
        if (is_pad || bad) begin
          err = 1'b1;
          v   = '0;
        end
        state_o.acc       = {v, 12'b0};
        state_o.third_pad = 1'b0;
        state_o.pos       = QPOS_SECOND;
      end
      QPOS_SECOND: begin
        if (is_pad || bad) begin
          err = 1'b1;
          v   = '0;
        end
        state_o.acc = state_i.acc | {6'b0, v, 6'b0};
        state_o.pos = QPOS_THIRD;
      end
      QPOS_THIRD: begin
        if (is_pad) begin
          state_o.third_pad = 1'b1;
          v = '0;
        end else if (bad) begin
          err = 1'b1;
          v   = '0;
        end
        state_o.acc = state_i.acc | {12'b0, v};
        state_o.pos = QPOS_FOURTH;
      end
      QPOS_FOURTH: begin
        d = pad3 ? 6'd0 : v;
        if (pad2 && !pad3) err = 1'b1;
        if ((pad2 || pad3) && !end_of_message_i) err = 1'b1;
        if (!pad3 && bad) err = 1'b1;
        // Leftover bits below the last whole byte must be zero.
        if (pad2 && state_i.acc[9:6] != 4'd0) err = 1'b1;
        if (pad3 && !pad2 && state_i.acc[1:0] != 2'd0) err = 1'b1;
        value = {state_i.acc, d};
        if (!err) begin
          group_o.res[n[1:0]] = '{byte_value: value[23:16], kind: KIND_DATA};
          n = n + 3'd1;
          if (!pad2) begin
            group_o.res[n[1:0]] = '{byte_value: value[15:8], kind: KIND_DATA};
            n = n + 3'd1;
          end
          if (!pad3) begin
            group_o.res[n[1:0]] = '{byte_value: value[7:0], kind: KIND_DATA};
            n = n + 3'd1;
          end
        end
        state_o.pos       = QPOS_FIRST;
        state_o.acc       = '0;
        state_o.third_pad = 1'b0;
      end
      default: begin
        state_o = state_i;
      end
    endcase

    state_o.err = err;

    if (end_of_message_i) begin
      if (state_i.pos != QPOS_FOURTH) err = 1'b1;
      group_o.res[n[1:0]] = '{byte_value: 8'h00, kind: (err ? KIND_ERR : KIND_OK)};
      n = n + 3'd1;
      state_o = '0;
    end

    group_o.num_res = n;
  end

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for base64_decoder_strict_core: directed messages, then random ones.
// Depends on b64d_pkg for the result kinds and the character constants.
// Each accepted character runs through a local decoder model; output transfers are checked in order.
`timescale 1ns / 1ps

module tb;
  import b64d_pkg::*;

  localparam int unsigned RandomItems = 330;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned CycleLimit  = 40000;
  localparam int unsigned DrainCycles = 16;

  typedef struct packed {
    logic [7:0] byte_value;
    kind_e      kind;
    logic       last;
  } dec_out_t;

  typedef struct {
    logic [7:0] ch;
    logic       eom;
    logic       typed;     // expected results are written in by hand
    logic       t_status;  // hand-written row ends in a status
    kind_e      t_kind;
  } dir_row_t;

  typedef struct {
    logic [7:0] ch;
    logic       eom;
  } char_item_t;

  logic       clk;
  logic       rst_n;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] char_code
  logic       s_tlast;   // end_of_message
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [7:0] byte_value
  logic [1:0] m_tuser;   // [1:0] kind
  logic       m_tlast;   // last_of_run

  // Decoder model state.
  logic [1:0]  mdl_pos;
  logic [17:0] mdl_acc;
  logic        mdl_third_pad;
  logic        mdl_err;

  dec_out_t   step_res[$];
  dec_out_t   decoded_q[$];
  dir_row_t   dir_rows[$];
  char_item_t rnd_chars[$];

  int unsigned cycle_cnt    = 0;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned ok_seen      = 0;
  int unsigned err_seen     = 0;
  int unsigned fail_cnt     = 0;
  logic        hold_req     = 1'b0;

  base64_decoder_strict_core u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Returns {in_alphabet, sextet}; the sextet is zero outside the alphabet.
  function automatic logic [6:0] char_sextet(input logic [7:0] ch);
    logic [6:0] r;
    r = 7'd0;
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)      r = {1'b1, 6'(ch - CH_UPPER_A)};
    else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) r = {1'b1, 6'(ch - CH_LOWER_A + 8'd26)};
    else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) r = {1'b1, 6'(ch - CH_DIGIT_0 + 8'd52)};
    else if (ch == CH_PLUS)                        r = {1'b1, SX_PLUS};
    else if (ch == CH_SLASH)                       r = {1'b1, SX_SLASH};
    return r;
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < SX_LOWER_BASE)      r = CH_UPPER_A + 8'(v);
    else if (v < SX_DIGIT_BASE) r = CH_LOWER_A + 8'(v - SX_LOWER_BASE);
    else if (v < SX_PLUS)       r = CH_DIGIT_0 + 8'(v - SX_DIGIT_BASE);
    else if (v == SX_PLUS)      r = CH_PLUS;
    else                        r = CH_SLASH;
    return r;
  endfunction

  function automatic void add_result(input logic [7:0] b, input kind_e k);
    dec_out_t r;
    r.byte_value = b;
    r.kind       = k;
    r.last       = 1'b0;
    step_res.insert(step_res.size(), r);
  endfunction

  function automatic void clear_decoder();
    mdl_pos       = QPOS_FIRST;
    mdl_acc       = 18'd0;
    mdl_third_pad = 1'b0;
    mdl_err       = 1'b0;
  endfunction

  // Works out the results that one character causes and advances the model.
  function automatic void decode_step(input logic [7:0] ch, input logic eom);
    logic [1:0]  pos;
    logic        is_pad;
    logic        in_set;
    logic [5:0]  v;
    logic        pad2;
    logic        pad3;
    logic [5:0]  b;
    logic [5:0]  c;
    logic [5:0]  d;
    logic [23:0] word;
    dec_out_t    tail;
    step_res.delete();
    pos    = mdl_pos;
    is_pad = (ch == CH_PAD);
    {in_set, v} = char_sextet(ch);
    case (pos)
      QPOS_FIRST, QPOS_SECOND: begin
        if (is_pad || !in_set) begin
          mdl_err = 1'b1;
          v = 6'd0;
        end
        if (pos == QPOS_FIRST) begin
          mdl_acc       = {v, 12'd0};
          mdl_third_pad = 1'b0;
        end else begin
          mdl_acc[11:6] = v;
        end
        mdl_pos = pos + 2'd1;
      end
      QPOS_THIRD: begin
        if (is_pad) begin
          mdl_third_pad = 1'b1;
          v = 6'd0;
        end else if (!in_set) begin
          mdl_err = 1'b1;
          v = 6'd0;
        end
        mdl_acc[5:0] = v;
        mdl_pos = QPOS_FOURTH;
      end
      default: begin
        pad2 = mdl_third_pad;
        pad3 = is_pad;
        b    = mdl_acc[11:6];
        c    = mdl_acc[5:0];
        d    = pad3 ? 6'd0 : v;
        if (pad2 && !pad3) mdl_err = 1'b1;
        if ((pad2 || pad3) && !eom) mdl_err = 1'b1;
        if (!pad3 && !in_set) mdl_err = 1'b1;
        if (pad2 && b[3:0] != 4'd0) mdl_err = 1'b1;
        if (pad3 && !pad2 && c[1:0] != 2'd0) mdl_err = 1'b1;
        if (!mdl_err) begin
          word = {mdl_acc, d};
          add_result(word[23:16], KIND_DATA);
          if (!pad2) add_result(word[15:8], KIND_DATA);
          if (!pad3) add_result(word[7:0], KIND_DATA);
        end
        mdl_pos       = QPOS_FIRST;
        mdl_acc       = 18'd0;
        mdl_third_pad = 1'b0;
      end
    endcase
    if (eom) begin
      if (pos != QPOS_FOURTH) mdl_err = 1'b1;
      add_result(8'd0, mdl_err ? KIND_ERR : KIND_OK);
      clear_decoder();
    end
    if (step_res.size() > 0) begin
      tail = step_res.pop_back();
      tail.last = 1'b1;
      step_res.insert(step_res.size(), tail);
    end
  endfunction

  function automatic void queue_step_results();
    foreach (step_res[i]) decoded_q.insert(decoded_q.size(), step_res[i]);
  endfunction

  task automatic add_row(input logic [7:0] ch, input logic eom, input logic typed,
                         input logic t_status, input kind_e t_kind);
    dir_row_t r;
    r.ch       = ch;
    r.eom      = eom;
    r.typed    = typed;
    r.t_status = t_status;
    r.t_kind   = t_kind;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // Offers one character and returns at the edge where the transfer happens.
  task automatic send_char(input logic [7:0] ch, input logic eom);
    logic quiet;
    quiet = (items_sent >= 250 && items_sent < 320);
    while (!quiet && $urandom_range(0, 99) < 9) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= eom;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Builds one random message; about half are left well formed.
  task automatic build_message();
    logic [7:0] msg[$];
    int unsigned nq;
    int unsigned pads;
    int unsigned mode;
    int unsigned len;
    logic [5:0] a, b, c, d;
    nq = $urandom_range(1, 4);
    for (int unsigned q = 0; q < nq; q++) begin
      pads = (q == nq - 1) ? $urandom_range(0, 2) : 0;
      a = 6'($urandom);
      b = 6'($urandom);
      c = 6'($urandom);
      d = 6'($urandom);
      if (pads == 2) b[3:0] = 4'd0;
      if (pads == 1) c[1:0] = 2'd0;
      msg.insert(msg.size(), sextet_char(a));
      msg.insert(msg.size(), sextet_char(b));
      msg.insert(msg.size(), pads == 2 ? CH_PAD : sextet_char(c));
      msg.insert(msg.size(), pads >= 1 ? CH_PAD : sextet_char(d));
    end
    mode = $urandom_range(0, 9);
    case (mode)
      0: msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
      1: msg[$urandom_range(0, msg.size() - 1)] = CH_PAD;
      2: if (msg.size() > 1) void'(msg.pop_back());
      3: msg.insert(msg.size(), sextet_char(6'($urandom)));
      4: begin
        msg.delete();
        len = $urandom_range(1, 9);
        repeat (len) msg.insert(msg.size(), 8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    foreach (msg[i]) begin
      char_item_t it;
      it.ch  = msg[i];
      it.eom = (i == msg.size() - 1);
      rnd_chars.insert(rnd_chars.size(), it);
    end
  endtask

  // Receiver: random stalls, one long hold-off on request, and a stall-free stretch.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= (results_seen >= 150 && results_seen < 230) || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  always @(posedge clk) begin : result_check
    dec_out_t exp_r;
    if (rst_n && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tuser == KIND_OK) ok_seen++;
      if (m_tuser == KIND_ERR) err_seen++;
      if (decoded_q.size() == 0) begin
        if (fail_cnt < 10)
          $display("unexpected transfer: byte %02h kind %0d last %0b",
                   m_tdata, m_tuser, m_tlast);
        fail_cnt++;
      end else begin
        exp_r = decoded_q.pop_front();
        if (m_tdata !== exp_r.byte_value || m_tuser !== exp_r.kind || m_tlast !== exp_r.last) begin
          if (fail_cnt < 10)
            $display("mismatch at result %0d: expected byte %02h kind %0d last %0b, %s %02h %0d %0b",
                     results_seen, exp_r.byte_value, exp_r.kind, exp_r.last, "got",
                     m_tdata, m_tuser, m_tlast);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               cycle_cnt, decoded_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    dec_out_t st;
    s_tvalid = 1'b0;
    s_tdata  = 8'd0;
    s_tlast  = 1'b0;
    rst_n    = 1'b0;
    clear_decoder();

    // Padding first, plus a length of one.
    add_row("=", 1'b1, 1'b1, 1'b1, KIND_ERR);
    // Two pads with clean leftover bits.
    add_row("Q", 1'b0, 1'b1, 1'b0, KIND_OK);
    add_row("Q", 1'b0, 1'b1, 1'b0, KIND_OK);
    add_row("=", 1'b0, 1'b1, 1'b0, KIND_OK);
    add_row("=", 1'b1, 1'b0, 1'b0, KIND_OK);
    // All-ones bytes.
    add_row("/", 1'b0, 1'b1, 1'b0, KIND_OK);
    add_row("/", 1'b0, 1'b1, 1'b0, KIND_OK);
    add_row("/", 1'b0, 1'b1, 1'b0, KIND_OK);
    add_row("/", 1'b1, 1'b0, 1'b0, KIND_OK);
    // Pad in the third position only.
    add_row("A", 1'b0, 1'b1, 1'b0, KIND_OK);
    add_row("A", 1'b0, 1'b1, 1'b0, KIND_OK);
    add_row("=", 1'b0, 1'b1, 1'b0, KIND_OK);
    add_row("A", 1'b1, 1'b1, 1'b1, KIND_ERR);
    // Two pads with leftover bits set.
    add_row("Q", 1'b0, 1'b1, 1'b0, KIND_OK);
    add_row("R", 1'b0, 1'b1, 1'b0, KIND_OK);
    add_row("=", 1'b0, 1'b1, 1'b0, KIND_OK);
    add_row("=", 1'b1, 1'b1, 1'b1, KIND_ERR);
    // One pad with leftover bits set.
    add_row("A", 1'b0, 1'b1, 1'b0, KIND_OK);
    add_row("A", 1'b0, 1'b1, 1'b0, KIND_OK);
    add_row("B", 1'b0, 1'b1, 1'b0, KIND_OK);
    add_row("=", 1'b1, 1'b1, 1'b1, KIND_ERR);
    // Padded quartet that is not final, then pad second and bytes outside the alphabet.
    add_row("A", 1'b0, 1'b1, 1'b0, KIND_OK);
    add_row("A", 1'b0, 1'b1, 1'b0, KIND_OK);
    add_row("=", 1'b0, 1'b1, 1'b0, KIND_OK);
    add_row("=", 1'b0, 1'b1, 1'b0, KIND_OK);
    add_row("A", 1'b0, 1'b1, 1'b0, KIND_OK);
    add_row("=", 1'b0, 1'b1, 1'b0, KIND_OK);
    add_row(8'hFF, 1'b0, 1'b1, 1'b0, KIND_OK);
    add_row(8'h00, 1'b1, 1'b1, 1'b1, KIND_ERR);

    while (rnd_chars.size() < RandomItems) build_message();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_char(dir_rows[i].ch, dir_rows[i].eom);
      decode_step(dir_rows[i].ch, dir_rows[i].eom);
      if (!dir_rows[i].typed) begin
        queue_step_results();
      end else if (dir_rows[i].t_status) begin
        st.byte_value = 8'd0;
        st.kind       = dir_rows[i].t_kind;
        st.last       = 1'b1;
        decoded_q.insert(decoded_q.size(), st);
      end
    end

    foreach (rnd_chars[i]) begin
      if (i == 80) hold_req = 1'b1;
      if (i == 180) begin
        // Let the output side catch up completely before carrying on.
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0) @(posedge clk);
      end
      send_char(rnd_chars[i].ch, rnd_chars[i].eom);
      decode_step(rnd_chars[i].ch, rnd_chars[i].eom);
      queue_step_results();
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (decoded_q.size() != 0) begin
      $display("%0d expected results never arrived", decoded_q.size());
      fail_cnt += decoded_q.size();
    end
    $display("Sent %0d characters (%0d directed) and checked %0d output transfers.",
             items_sent, dir_rows.size(), results_seen);
    $display("Messages closed: %0d good, %0d rejected; %0d failures seen.",
             ok_seen, err_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
